// File: rtl/met_pkg.sv
`timescale 1ns / 1ps
package met_pkg;

   // register indexes on the csr port
   localparam logic [2:0] REG_X_START = 3'd0;
   localparam logic [2:0] REG_Y_START = 3'd1;
   localparam logic [2:0] REG_X_STEP  = 3'd2;
   localparam logic [2:0] REG_Y_STEP  = 3'd3;
   localparam logic [2:0] REG_LIMIT   = 3'd4;

   localparam int IDX_W   = 10;
   localparam int CNT_W   = 16;
   localparam int COORD_W = 32;
   // arrival order tag, enough for the three pixels in flight
   localparam int TAG_W   = 2;

   // iteration context carried around the stage ring
   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [IDX_W-1:0]   xi;
      logic [IDX_W-1:0]   yi;
      logic signed [COORD_W-1:0] cr;
      logic signed [COORD_W-1:0] ci;
      logic signed [COORD_W-1:0] zr;
      logic signed [COORD_W-1:0] zi;
      logic [CNT_W-1:0]   n;
      logic               done;
      logic [CNT_W-1:0]   count;
   } ctx_type;

endpackage

// File: rtl/met_coord.sv
`timescale 1ns / 1ps
// Pixel coordinate: clamp indices, c = start + index*step, saturate.
// Two register stages: product, then sum and saturate.
module met_coord #(
   parameter int GRID_SIZE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [met_pkg::IDX_W-1:0] x_index,
   input  logic [met_pkg::IDX_W-1:0] y_index,
   input  logic signed [31:0] x_start,
   input  logic signed [31:0] y_start,
   input  logic signed [31:0] x_step,
   input  logic signed [31:0] y_step,
   output logic        out_valid,
   output logic [met_pkg::IDX_W-1:0] out_xi,
   output logic [met_pkg::IDX_W-1:0] out_yi,
   output logic signed [31:0] out_cr,
   output logic signed [31:0] out_ci
);
   localparam int GW = 17;
   localparam logic [GW-1:0] MAX_IDX = GW'(GRID_SIZE - 1);

   logic [met_pkg::IDX_W-1:0] xc, yc;
   logic v1_ff, v2_ff;
   logic [met_pkg::IDX_W-1:0] xi1_ff, yi1_ff, xi2_ff, yi2_ff;
   logic signed [42:0] px_ff, py_ff;
   logic signed [31:0] cr_ff, ci_ff;
   logic signed [43:0] sx, sy;

   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      if (v > 44'sd2147483647) return 32'sh7fffffff;
      if (v < -44'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   always_comb begin
      xc = ({7'd0, x_index} > MAX_IDX) ? MAX_IDX[met_pkg::IDX_W-1:0] : x_index;
      yc = ({7'd0, y_index} > MAX_IDX) ? MAX_IDX[met_pkg::IDX_W-1:0] : y_index;
      sx = 44'(px_ff) + 44'(x_start);
      sy = 44'(py_ff) + 44'(y_start);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (enable) begin
         px_ff  <= $signed({1'b0, xc}) * x_step;
         py_ff  <= $signed({1'b0, yc}) * y_step;
         xi1_ff <= xc;
         yi1_ff <= yc;
         cr_ff  <= sat32(sx);
         ci_ff  <= sat32(sy);
         xi2_ff <= xi1_ff;
         yi2_ff <= yi1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_xi = xi2_ff;
   assign out_yi = yi2_ff;
   assign out_cr = cr_ff;
   assign out_ci = ci_ff;
endmodule

// File: rtl/met_iter.sv
`timescale 1ns / 1ps
// One z = z*z + c iteration in three stages: multiply, sum, escape test.
module met_iter #(
   parameter int FRAC_BITS = 28
) (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic [met_pkg::CNT_W-1:0] limit,
   input  met_pkg::ctx_type ctx_in,
   output met_pkg::ctx_type ctx_out
);
   localparam int W = 32;
   localparam logic signed [W+1:0] TWO = (W+2)'(64'sd2 <<< FRAC_BITS);
   localparam logic signed [2*W+3:0] FOUR_SQ = (2*W+4)'(64'sd4 <<< (2*FRAC_BITS));

   met_pkg::ctx_type c1_ff, c2_ff, c3_ff, c3_in;
   logic signed [2*W-1:0] rr_ff, ii_ff, ri_ff;
   logic signed [W+1:0] nr_ff, ni_ff;
   logic signed [2*W-1:0] rrs, iis, ris;
   logic signed [W+1:0] nr, ni;
   logic signed [2*W+3:0] mag;
   logic big, active, esc;

   always_comb begin
      rrs = rr_ff >>> FRAC_BITS;
      iis = ii_ff >>> FRAC_BITS;
      ris = ri_ff >>> FRAC_BITS;
      nr  = (W+2)'(rrs) - (W+2)'(iis) + (W+2)'(c1_ff.cr);
      ni  = (W+2)'(ris <<< 1) + (W+2)'(c1_ff.ci);
      big = (nr_ff > TWO) || (nr_ff < -TWO) || (ni_ff > TWO) || (ni_ff < -TWO);
      mag = (2*W+4)'(nr_ff * nr_ff) + (2*W+4)'(ni_ff * ni_ff);
      active = c2_ff.valid && !c2_ff.done && (c2_ff.n < limit);
      esc = big || (mag > FOUR_SQ);
   end

   // escape test stage: count, finish or keep the new z
   always_comb begin
      c3_in = c2_ff;
      if (active) begin
         c3_in.n = c2_ff.n + 1'b1;
         if (esc) begin
            c3_in.done  = 1'b1;
            c3_in.count = c2_ff.n + 1'b1;
         end else begin
            c3_in.zr = nr_ff[W-1:0];
            c3_in.zi = ni_ff[W-1:0];
         end
      end else if (c2_ff.valid) begin
         c3_in.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
      end else if (enable) begin
         c1_ff <= ctx_in;
         rr_ff <= ctx_in.zr * ctx_in.zr;
         ii_ff <= ctx_in.zi * ctx_in.zi;
         ri_ff <= ctx_in.zr * ctx_in.zi;
         c2_ff <= c1_ff;
         nr_ff <= nr;
         ni_ff <= ni;
         c3_ff <= c3_in;
      end
   end

   assign ctx_out = c3_ff;
endmodule

// File: rtl/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps
// Escape-time pixel engine. Pixels circulate in a 3-stage iteration ring, one z*z+c
// step per pass. A pixel escaping at iteration n makes n passes, one that never escapes
// makes iteration_limit + 1; before rsp_valid it also waits for a ring slot, for older
// pixels and for the output. Results leave in order. Up to three pixels share the ring.
// Reset (synchronous, active high) restores register defaults and empties the ring.
module mandelbrot_escape_time_unit #(
   parameter int GRID_SIZE = 1024,
   parameter int FRAC_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_x_index,
   input  logic [9:0]  req_y_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_escape_count,
   output logic [9:0]  rsp_out_x_index,
   output logic [9:0]  rsp_out_y_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic signed [31:0] x_start_ff, y_start_ff, x_step_ff, y_step_ff;
   logic [15:0] limit_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff <= -32'sd536870912;
         y_start_ff <= -32'sd536870912;
         x_step_ff  <= 32'sd1050628;
         y_step_ff  <= 32'sd1050628;
         limit_ff   <= 16'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            met_pkg::REG_X_START: x_start_ff <= csr_data;
            met_pkg::REG_Y_START: y_start_ff <= csr_data;
            met_pkg::REG_X_STEP:  x_step_ff  <= csr_data;
            met_pkg::REG_Y_STEP:  y_step_ff  <= csr_data;
            met_pkg::REG_LIMIT:   limit_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // ring: feedback word leaves when done, oldest and output slot free; new pixel fills holes.
   // Coordinate stages advance only when ring slot can take them.
   met_pkg::ctx_type fb, ring_in, entry;
   logic cv;
   logic [9:0] cxi, cyi;
   logic signed [31:0] ccr, cci;
   logic out_v_ff;
   logic [15:0] out_cnt_ff;
   logic [9:0] out_x_ff, out_y_ff;
   logic retire, hole, coord_en, ring_en, admit;
   logic [1:0] inflight_ff, inflight_in;
   logic [met_pkg::TAG_W-1:0] admit_tag_ff, head_tag_ff;

   // no stall inside the ring; only whether a slot is free
   assign ring_en = 1'b1;
   // done pixels that are not the oldest, or that find the output register full, take another lap
   assign retire = fb.valid && fb.done && (fb.tag == head_tag_ff) && (!out_v_ff || rsp_ready);
   assign hole = !fb.valid || retire;
   assign admit = hole && cv;
   assign coord_en = hole || !cv;
   // limit work in coord so we never drop: two stage buffer holds while no hole
   assign req_ready = coord_en && (inflight_ff < 2'd3 || retire);

   always_comb begin
      entry = '0;
      entry.valid = cv;
      entry.tag = admit_tag_ff;
      entry.xi = cxi;
      entry.yi = cyi;
      entry.cr = ccr;
      entry.ci = cci;
      ring_in = fb;
      if (hole) ring_in = entry;
      inflight_in = inflight_ff + 2'((req_valid && req_ready) ? 1 : 0)
                    - 2'(retire ? 1 : 0);
   end

   met_coord #(.GRID_SIZE(GRID_SIZE)) u_coord (
      .clock(clock), .reset(reset), .enable(coord_en),
      .in_valid(req_valid && req_ready),
      .x_index(req_x_index), .y_index(req_y_index),
      .x_start(x_start_ff), .y_start(y_start_ff),
      .x_step(x_step_ff), .y_step(y_step_ff),
      .out_valid(cv), .out_xi(cxi), .out_yi(cyi), .out_cr(ccr), .out_ci(cci)
   );

   met_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
      .clock(clock), .reset(reset), .enable(ring_en), .limit(limit_ff),
      .ctx_in(ring_in), .ctx_out(fb)
   );

   // output register and order tags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         inflight_ff <= 2'd0;
         admit_tag_ff <= '0;
         head_tag_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
         if (admit) admit_tag_ff <= admit_tag_ff + 1'b1;
         if (retire) head_tag_ff <= head_tag_ff + 1'b1;
         if (retire) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
      if (retire) begin
         out_cnt_ff <= fb.count;
         out_x_ff <= fb.xi;
         out_y_ff <= fb.yi;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_escape_count = out_cnt_ff;
   assign rsp_out_x_index = out_x_ff;
   assign rsp_out_y_index = out_y_ff;
endmodule

// File: tb/mandelbrot_escape_time_unit_tb.sv
`timescale 1ns / 1ps
module mandelbrot_escape_time_unit_tb;

   // indexes past the register list, writes there must be dropped
   localparam logic [2:0] REG_SPARE_A = 3'd5;
   localparam logic [2:0] REG_SPARE_B = 3'd7;
   localparam int FRAC = 28;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [9:0] x;
      logic [9:0] y;
   } pixel_type;

   typedef struct packed {
      logic [15:0] count;
      logic [9:0]  x;
      logic [9:0]  y;
   } escape_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [9:0]  req_x_index = '0;
   logic [9:0]  req_y_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_escape_count;
   logic [9:0]  rsp_out_x_index;
   logic [9:0]  rsp_out_y_index;
   logic        csr_valid = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        csr_ready;

   // local copy of the plane setup
   logic signed [31:0] plane_x0, plane_y0, plane_dx, plane_dy;
   logic [15:0]        plane_limit;

   pixel_type  pixel_queue[$];
   escape_type escape_queue[$];
   int      send_idle = 0;
   int      recv_idle = 0;
   int      mismatches = 0;

   mandelbrot_escape_time_unit u_top (.*);

   always #5 clock = ~clock;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // escape iteration of one pixel under the current plane setup
   function automatic logic [15:0] escape_iteration(logic [9:0] xi, logic [9:0] yi);
      longint cr, ci, zr, zi, nr, ni, two, four_sq;
      cr = sat32(longint'(plane_x0) + longint'(xi) * longint'(plane_dx));
      ci = sat32(longint'(plane_y0) + longint'(yi) * longint'(plane_dy));
      two = 64'sd2 <<< FRAC;
      four_sq = 64'sd4 <<< (2 * FRAC);
      zr = 0;
      zi = 0;
      for (int n = 1; n <= plane_limit; n++) begin
         nr = ((zr * zr) >>> FRAC) - ((zi * zi) >>> FRAC) + cr;
         ni = 2 * ((zr * zi) >>> FRAC) + ci;
         if (nr > two || nr < -two || ni > two || ni < -two) return 16'(n);
         if (nr * nr + ni * ni > four_sq) return 16'(n);
         zr = nr;
         zi = ni;
      end
      return 16'd0;
   endfunction

   // driver: predicts each accepted word, then offers the next one
   always @(posedge clock) begin
      pixel_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            escape_queue.push_back({escape_iteration(req_x_index, req_y_index),
                                    req_x_index, req_y_index});
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
               p = pixel_queue.pop_front();
               req_valid   <= 1'b1;
               req_x_index <= p.x;
               req_y_index <= p.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      escape_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (escape_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result count=%0d x=%0d y=%0d", rsp_escape_count,
                           rsp_out_x_index, rsp_out_y_index);
            end else begin
               e = escape_queue.pop_front();
               if (e.count !== rsp_escape_count || e.x !== rsp_out_x_index ||
                   e.y !== rsp_out_y_index) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp count=%0d x=%0d y=%0d got count=%0d x=%0d y=%0d",
                              e.count, e.x, e.y, rsp_escape_count, rsp_out_x_index,
                              rsp_out_y_index);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         met_pkg::REG_X_START: plane_x0 = value;
         met_pkg::REG_Y_START: plane_y0 = value;
         met_pkg::REG_X_STEP:  plane_dx = value;
         met_pkg::REG_Y_STEP:  plane_dy = value;
         met_pkg::REG_LIMIT:   plane_limit = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_plane(logic [31:0] x0, logic [31:0] y0, logic [31:0] dx,
                            logic [31:0] dy, logic [15:0] lim);
      csr_write(met_pkg::REG_X_START, x0);
      csr_write(met_pkg::REG_Y_START, y0);
      csr_write(met_pkg::REG_X_STEP, dx);
      csr_write(met_pkg::REG_Y_STEP, dy);
      csr_write(met_pkg::REG_LIMIT, {16'd0, lim});
   endtask

   // block until every word is accepted and answered, then let the ring settle;
   // checked mid-cycle so the driver and monitor updates have landed
   task automatic drain();
      while (pixel_queue.size() != 0 || req_valid || escape_queue.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic push_pixel(logic [9:0] x, logic [9:0] y);
      pixel_queue.push_back({x, y});
   endtask

   initial begin
      logic [31:0] x0, y0, dx, dy;
      logic [15:0] lim;
      plane_x0 = -32'sd536870912;
      plane_y0 = -32'sd536870912;
      plane_dx = 32'sd1050628;
      plane_dy = 32'sd1050628;
      plane_limit = 16'd256;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle = 14;
      recv_idle = 68;

      // reset setup, grid corners, center and an inner point
      push_pixel(10'd0, 10'd0);
      push_pixel(10'd1023, 10'd1023);
      push_pixel(10'd0, 10'd1023);
      push_pixel(10'd1023, 10'd0);
      push_pixel(10'd512, 10'd512);
      push_pixel(10'h2AA, 10'h155);
      drain();

      // limit zero never iterates; spare indexes are ignored
      csr_write(met_pkg::REG_LIMIT, 32'd0);
      csr_write(REG_SPARE_A, 32'hFFFF_FFFF);
      csr_write(REG_SPARE_B, 32'h1234_5678);
      push_pixel(10'd0, 10'd0);
      push_pixel(10'd1023, 10'd1023);
      drain();

      // saturating coordinates, single iteration
      set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
      push_pixel(10'd0, 10'd0);
      push_pixel(10'd1023, 10'd1023);
      push_pixel(10'd1, 10'd1);
      drain();
      set_plane(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 16'd3);
      push_pixel(10'd5, 10'd9);
      push_pixel(10'd1023, 10'd0);
      drain();

      // origin never escapes: longest possible run
      set_plane(32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF);
      push_pixel(10'd0, 10'd0);
      push_pixel(10'd1023, 10'd1023);
      push_pixel(10'd17, 10'd300);
      drain();
      // c just below -2 escapes at once, c = -2 sits on the boundary for the full run
      set_plane(32'hE000_0000 - 32'd1, 32'h0, 32'h1, 32'h0, 16'hFFFF);
      push_pixel(10'd0, 10'd0);
      push_pixel(10'd1, 10'd0);
      drain();

      // random part: three idle profiles, several planes each
      for (int mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 14 : (mode == 1) ? 68 : 0;
         recv_idle = (mode == 0) ? 68 : (mode == 1) ? 14 : 0;
         for (int sub = 0; sub < 6; sub++) begin
            if ($urandom_range(4) == 0) begin
               x0 = $urandom;
               y0 = $urandom;
               dx = $urandom;
               dy = $urandom;
            end else begin
               x0 = 32'hD800_0000 + $urandom_range(0, 32'h1000_0000);
               y0 = 32'hE000_0000 + $urandom_range(0, 32'h0800_0000);
               dx = $urandom_range(0, 800000);
               dy = $urandom_range(0, 600000);
               if ($urandom_range(1)) dy = -dy;
            end
            lim = ($urandom_range(5) == 0) ? 16'd1 : 16'($urandom_range(2, 80));
            set_plane(x0, y0, dx, dy, lim);
            for (int k = 0; k < 100; k++) begin
               push_pixel(10'($urandom), 10'($urandom));
               // hold the sender until the ring has emptied once
               if (mode == 0 && sub == 2 && k == 50) drain();
            end
            drain();
         end
      end

      if (mismatches == 0 && escape_queue.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
